FILE: sv/vtpd_pkg.sv
`default_nettype none
package vtpd_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_REGS      = 8;
	localparam int CFG_IDX_W     = 4;

	typedef struct packed {
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
		logic signed [31:0] in_w;
	} vtx_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_w;
		logic               was_divided;
	} vtx_out_t;

	// [row][col] entries, Q format
	typedef logic [3:0][3:0][31:0] mat_t;
	// transformed components, index 3 is w
	typedef logic [3:0][31:0] vec4_t;

endpackage
`default_nettype wire

FILE: sv/vertex_transform_perspective_divide.sv
// channel   dir  handshake                   payload
// vertex    in   vertex_valid/vertex_stall   vtx_in_t
// result    out  result_valid/result_stall   vtx_out_t
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// One vertex per cycle while the pipe is not frozen by a result stall: three
// multiply/sum/saturate stages, one prep stage, one divider stage per
// quotient bit (32 + FRAC_BITS), and the output register.
// Reset loads the identity matrix. A stall on a valid result freezes the whole pipe.
`default_nettype none
module vertex_transform_perspective_divide import vtpd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vertex_valid,
	output logic                 vertex_stall,
	input  vtx_in_t              vertex,
	output logic                 result_valid,
	input  logic                 result_stall,
	output vtx_out_t             result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	logic [63:0] mreg_q [NUM_REGS];
	mat_t        mat;
	logic        en;
	logic        t_valid, d_valid;
	vec4_t       t;
	vtx_out_t    d_res;
	logic        res_valid_q;
	vtx_out_t    res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mreg_q[0] <= {32'd0, ONE};
			mreg_q[1] <= 64'd0;
			mreg_q[2] <= {ONE, 32'd0};
			mreg_q[3] <= 64'd0;
			mreg_q[4] <= 64'd0;
			mreg_q[5] <= {32'd0, ONE};
			mreg_q[6] <= 64'd0;
			mreg_q[7] <= {ONE, 32'd0};
		end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			mreg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			mat[r][0] = mreg_q[2*r][31:0];
			mat[r][1] = mreg_q[2*r][63:32];
			mat[r][2] = mreg_q[2*r+1][31:0];
			mat[r][3] = mreg_q[2*r+1][63:32];
		end
	end

	assign en           = !res_valid_q || !result_stall;
	assign vertex_stall = !en;

	vtpd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (vertex_valid),
		.vin     (vertex),
		.mat     (mat),
		.t_valid (t_valid),
		.t       (t)
	);

	vtpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.t_valid   (t_valid),
		.t         (t),
		.res_valid (d_valid),
		.res       (d_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (en)
			res_valid_q <= d_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			res_q <= d_res;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire

FILE: sv/vtpd_mac.sv
`default_nettype none
module vtpd_mac import vtpd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    valid,
	input  vtx_in_t vin,
	input  mat_t    mat,
	output logic    t_valid,
	output vec4_t   t
);

	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

	logic signed [31:0] v [4];
	logic signed [63:0] prod_s1 [4][4];
	logic signed [65:0] sum_s2 [4];
	logic signed [65:0] shr [4];
	vec4_t              t_s3;
	logic               valid_s1, valid_s2, valid_s3;

	assign v[0] = vin.in_x;
	assign v[1] = vin.in_y;
	assign v[2] = vin.in_z;
	assign v[3] = vin.in_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++)
			shr[r] = sum_s2[r] >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++)
					prod_s1[r][c] <= $signed(mat[r][c]) * v[c];
				sum_s2[r] <= {{2{prod_s1[r][0][63]}}, prod_s1[r][0]}
					+ {{2{prod_s1[r][1][63]}}, prod_s1[r][1]}
					+ {{2{prod_s1[r][2][63]}}, prod_s1[r][2]}
					+ {{2{prod_s1[r][3][63]}}, prod_s1[r][3]};
				if (shr[r] > SAT_MAX)
					t_s3[r] <= 32'h7fff_ffff;
				else if (shr[r] < SAT_MIN)
					t_s3[r] <= 32'h8000_0000;
				else
					t_s3[r] <= shr[r][31:0];
			end
		end
	end

	assign t_valid = valid_s3;
	assign t       = t_s3;

endmodule
`default_nettype wire

FILE: sv/vtpd_div.sv
`default_nettype none
module vtpd_div import vtpd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     t_valid,
	input  vec4_t    t,
	output logic     res_valid,
	output vtx_out_t res
);

	localparam int QW = 32 + FRAC_BITS;
	localparam logic [QW-1:0] QPOS_MAX = {{(QW-32){1'b0}}, 32'h7fff_ffff};
	localparam logic [QW-1:0] QNEG_MAX = {{(QW-32){1'b0}}, 32'h8000_0000};

	typedef struct packed {
		vec4_t      t;
		logic [2:0] neg;
		logic       div;
		logic [31:0] aw;
	} side_t;

	logic          vld_s  [QW+1];
	side_t         side_s [QW+1];
	logic [31:0]   rem_s  [QW+1][3];
	logic [QW-1:0] nq_s   [QW+1][3];

	logic [31:0] mag [3];
	logic [31:0] aw;

	assign aw = t[3][31] ? (~t[3] + 32'd1) : t[3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag[i] = t[i][31] ? (~t[i] + 32'd1) : t[i];
	end

	// operand prep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= t_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0].t   <= t;
			side_s[0].div <= (t[3] != 32'd0);
			side_s[0].aw  <= aw;
			for (int i = 0; i < 3; i++) begin
				side_s[0].neg[i] <= t[i][31] ^ t[3][31];
				rem_s[0][i]      <= 32'd0;
				nq_s[0][i]       <= {mag[i], {FRAC_BITS{1'b0}}};
			end
		end
	end

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [32:0] trial [3];
		logic        ge    [3];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				trial[i] = {rem_s[k][i], nq_s[k][i][QW-1]};
				ge[i]    = trial[i] >= {1'b0, side_s[k].aw};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				for (int i = 0; i < 3; i++) begin
					rem_s[k+1][i] <= ge[i] ? 32'(trial[i] - {1'b0, side_s[k].aw})
						: trial[i][31:0];
					nq_s[k+1][i]  <= {nq_s[k][i][QW-2:0], ge[i]};
				end
			end
		end
	end

	logic [31:0] q_out [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!side_s[QW].div)
				q_out[i] = side_s[QW].t[i];
			else if (side_s[QW].neg[i])
				q_out[i] = (nq_s[QW][i] > QNEG_MAX) ? 32'h8000_0000
					: (~nq_s[QW][i][31:0] + 32'd1);
			else
				q_out[i] = (nq_s[QW][i] > QPOS_MAX) ? 32'h7fff_ffff
					: nq_s[QW][i][31:0];
		end
	end

	assign res_valid       = vld_s[QW];
	assign res.out_x       = q_out[0];
	assign res.out_y       = q_out[1];
	assign res.out_z       = q_out[2];
	assign res.out_w       = side_s[QW].t[3];
	assign res.was_divided = side_s[QW].div;

endmodule
`default_nettype wire
